// ===== design/offense_lockout_table_unit_defines.svh =====
// Assertion macros for the offense lockout table unit
`ifndef OFFENSE_LOCKOUT_TABLE_UNIT_DEFINES_SVH
`define OFFENSE_LOCKOUT_TABLE_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define OLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/olt_pkg.sv =====
// Package: types, constants and codes for the offense lockout table unit
package olt_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned KeyW = 48;
  localparam int unsigned TimeW = 32;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [7:0] CountMax = 8'hFF;
  localparam logic [7:0] LimitReset = 8'd3;
  localparam logic [15:0] LockoutReset = 16'd60;
  localparam logic [15:0] IntervalReset = 16'd20;

  localparam logic [1:0] ModeCheck = 2'd0;
  localparam logic [1:0] ModeOffense = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;

  localparam logic [1:0] RegLimit = 2'd0;
  localparam logic [1:0] RegLockout = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [KeyW-1:0] peer_address;
  } in_item_t;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StSweep,
    StScan,
    StUpdate,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic sweep_start;
    logic sweep_step;
    logic scan_clear;
    logic scan_step;
    logic update;
    logic tick;
  } cmd_t;

  typedef struct packed {
    logic sweep_due;
    logic idx_last;
  } stat_t;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction
endpackage

// ===== design/offense_lockout_table_unit.sv =====
// Top level of the offense lockout table unit
// Usage:
//   Input channel in_valid_i/in_stall_o carries one item {mode, peer_address}.
//   mode check: runs the periodic sweep if due, then reports whether blocked.
//   mode offense: records an offense, may block or flag table_full.
//   mode tick: advances the seconds clock by one (saturating).
//   Output channel out_valid_o/out_stall_i returns one {allowed, table_full}.
// Steps per item: tick and the unused mode 3 go straight to output; offense
//   walks the 16-entry scan, then update, then output; check first runs the
//   sweep walk if one is due, then the same scan, update and output. The earliest
//   next accept comes in the cycle after the result transfers. Each walk visits one table entry per cycle.
// One item is in flight; in_stall_o stays high until its result transfers.
// A stalled result holds on out_item_o until out_stall_i drops.
// Reset clears the table, the clock and the sweep deadline, and loads
//   registers offense_limit 3, block duration 60, sweep_interval 20.
// Registers over APB at byte offsets 0, 4, 8; pready is always high.
`include "offense_lockout_table_unit_defines.svh"
module offense_lockout_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  olt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output olt_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [7:0]     limit_q;
  logic [15:0]    lockout_q, interval_q;
  olt_pkg::cmd_t  cmd;
  olt_pkg::stat_t stat;
  logic [1:0]     reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= olt_pkg::LimitReset;
      lockout_q <= olt_pkg::LockoutReset;
      interval_q <= olt_pkg::IntervalReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        olt_pkg::RegLimit:    limit_q <= pwdata[7:0];
        olt_pkg::RegLockout:  lockout_q <= pwdata[15:0];
        olt_pkg::RegInterval: interval_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      olt_pkg::RegLimit:    prdata = {24'd0, limit_q};
      olt_pkg::RegLockout:  prdata = {16'd0, lockout_q};
      olt_pkg::RegInterval: prdata = {16'd0, interval_q};
      default:              prdata = '0;
    endcase
  end

  olt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .mode_i(in_item_i.mode), .stat_i(stat), .cmd_o(cmd),
    .out_valid_o, .out_stall_i
  );

  olt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .in_item_i,
    .limit_i(limit_q), .lockout_i(lockout_q), .interval_i(interval_q),
    .out_item_o
  );

  `OLT_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `OLT_ASSERT_IMP(a_full_allowed, clk_i, rst_ni, out_valid_o && out_item_o.table_full, out_item_o.allowed)
  `OLT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

// ===== design/olt_ctrl.sv =====
// Controller state machine for the offense lockout table unit
module olt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  input  olt_pkg::stat_t stat_i,
  output olt_pkg::cmd_t  cmd_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);
  olt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      olt_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d = olt_pkg::StScan;
          if (mode_i == olt_pkg::ModeCheck) begin
            cmd_o.sweep_start = 1'b1;
            state_d = olt_pkg::StSweep;
          end else if (mode_i != olt_pkg::ModeOffense) begin
            cmd_o.tick = (mode_i == olt_pkg::ModeTick);
            state_d = olt_pkg::StOut;
          end
        end
      end
      olt_pkg::StSweep: begin
        if (!stat_i.sweep_due) begin
          state_d = olt_pkg::StScan;
        end else begin
          cmd_o.sweep_step = 1'b1;
          if (stat_i.idx_last) state_d = olt_pkg::StScan;
        end
      end
      olt_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.idx_last) state_d = olt_pkg::StUpdate;
      end
      olt_pkg::StUpdate: begin
        cmd_o.update = 1'b1;
        state_d = olt_pkg::StOut;
      end
      olt_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = olt_pkg::StIdle;
      end
      default: state_d = olt_pkg::StIdle;
    endcase
  end
endmodule

// ===== design/olt_datapath.sv =====
// Datapath: entry table, clocks, sweep and lookup walk for the lockout table
module olt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  olt_pkg::cmd_t     cmd_i,
  output olt_pkg::stat_t    stat_o,
  input  olt_pkg::in_item_t in_item_i,
  input  logic [7:0]        limit_i,
  input  logic [15:0]       lockout_i,
  input  logic [15:0]       interval_i,
  output olt_pkg::out_item_t out_item_o
);
  logic [olt_pkg::Entries-1:0] valid_q, valid_d, blocked_q, blocked_d;
  logic [olt_pkg::KeyW-1:0]  key_q [olt_pkg::Entries];
  logic [7:0]                cnt_q [olt_pkg::Entries];
  logic [olt_pkg::TimeW-1:0] tim_q [olt_pkg::Entries];
  logic [olt_pkg::TimeW-1:0] clock_q, next_sweep_q;
  logic [olt_pkg::IdxW-1:0]  idx_q;
  logic [1:0]                mode_q;
  logic [olt_pkg::KeyW-1:0]  addr_q;
  logic                      hit_q, free_q;
  logic [olt_pkg::IdxW-1:0]  hit_idx_q, free_idx_q;
  logic                      allowed_q, full_q;
  logic [olt_pkg::TimeW:0]   stale_sum;
  logic                      drop;
  logic [7:0]                cnt_inc;
  logic                      sweep_due_now;
  logic                      sweep_act_q;

  // deadline test is taken once at sweep start, before the deadline moves
  assign sweep_due_now = (clock_q >= next_sweep_q);
  assign stat_o.sweep_due = sweep_act_q;
  assign stat_o.idx_last = (idx_q == olt_pkg::IdxW'(olt_pkg::Entries - 1));
  assign out_item_o.allowed = allowed_q;
  assign out_item_o.table_full = full_q;

  assign stale_sum = {1'b0, tim_q[idx_q]} + {17'd0, lockout_i};
  assign drop = blocked_q[idx_q] ? (tim_q[idx_q] < clock_q)
                                 : (stale_sum < {1'b0, clock_q});
  assign cnt_inc = (cnt_q[hit_idx_q] == olt_pkg::CountMax) ? cnt_q[hit_idx_q]
                                                           : cnt_q[hit_idx_q] + 8'd1;

  always_comb begin
    valid_d = valid_q;
    blocked_d = blocked_q;
    if (cmd_i.sweep_step && drop) valid_d[idx_q] = 1'b0;
    if (cmd_i.update && mode_q == olt_pkg::ModeOffense) begin
      if (hit_q) begin
        if (!blocked_q[hit_idx_q] && cnt_inc >= limit_i) blocked_d[hit_idx_q] = 1'b1;
      end else if (free_q) begin
        valid_d[free_idx_q] = 1'b1;
        blocked_d[free_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      blocked_q <= '0;
      clock_q <= '0;
      next_sweep_q <= '0;
      idx_q <= '0;
      sweep_act_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      blocked_q <= blocked_d;
      if (cmd_i.tick) clock_q <= olt_pkg::sat_add(clock_q, 32'd1);
      if (cmd_i.sweep_start) sweep_act_q <= sweep_due_now;
      if (cmd_i.sweep_start && sweep_due_now)
        next_sweep_q <= olt_pkg::sat_add(clock_q, {16'd0, interval_i});
      if (cmd_i.scan_clear) idx_q <= '0;
      else if (cmd_i.sweep_step || cmd_i.scan_step) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_item_i.mode;
      addr_q <= in_item_i.peer_address;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      allowed_q <= 1'b1;
      full_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (valid_q[idx_q] && key_q[idx_q] == addr_q && !hit_q) begin
        hit_q <= 1'b1;
        hit_idx_q <= idx_q;
        if (blocked_q[idx_q]) allowed_q <= 1'b0;
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_q <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.update && mode_q == olt_pkg::ModeOffense) begin
      if (hit_q) begin
        if (!blocked_q[hit_idx_q]) begin
          cnt_q[hit_idx_q] <= cnt_inc;
          if (cnt_inc >= limit_i) begin
            tim_q[hit_idx_q] <= olt_pkg::sat_add(clock_q, {16'd0, lockout_i});
            allowed_q <= 1'b0;
          end else begin
            tim_q[hit_idx_q] <= clock_q;
          end
        end
      end else if (free_q) begin
        key_q[free_idx_q] <= addr_q;
        cnt_q[free_idx_q] <= 8'd1;
        tim_q[free_idx_q] <= clock_q;
      end else begin
        full_q <= 1'b1;
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the offense lockout table unit: directed table plus random traffic vs predictor
`timescale 1ns / 100ps
module tb_top;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandItems = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  olt_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  olt_pkg::out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  offense_lockout_table_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic                      tv_valid [olt_pkg::Entries];
  logic                      tv_blocked [olt_pkg::Entries];
  logic [olt_pkg::KeyW-1:0]  tv_key [olt_pkg::Entries];
  logic [7:0]                tv_count [olt_pkg::Entries];
  logic [olt_pkg::TimeW-1:0] tv_time [olt_pkg::Entries];
  logic [olt_pkg::TimeW-1:0] now_sec, sweep_due_at;
  logic [7:0]  lim_r;
  logic [15:0] lock_r, intv_r;

  olt_pkg::out_item_t verdict_q[$];
  int mismatches = 0;
  int send_idle = 12, recv_idle = 53;
  bit holding = 1'b0;
  int unsigned quiet = 0;
  logic [olt_pkg::KeyW-1:0] keys [8];

  function automatic logic [olt_pkg::TimeW-1:0] add_sat(logic [olt_pkg::TimeW-1:0] a,
                                                        logic [olt_pkg::TimeW-1:0] b);
    logic [olt_pkg::TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[olt_pkg::TimeW] ? '1 : s[olt_pkg::TimeW-1:0];
  endfunction

  function automatic logic [olt_pkg::KeyW-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[olt_pkg::KeyW-1:0];
  endfunction

  function automatic int find_peer(logic [olt_pkg::KeyW-1:0] k);
    for (int i = 0; i < olt_pkg::Entries; i++) if (tv_valid[i] && tv_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void run_sweep();
    if (now_sec < sweep_due_at) return;
    sweep_due_at = add_sat(now_sec, {16'd0, intv_r});
    for (int i = 0; i < olt_pkg::Entries; i++) begin
      if (!tv_valid[i]) continue;
      if (tv_blocked[i]) begin
        if (tv_time[i] < now_sec) tv_valid[i] = 1'b0;
      end else if ({1'b0, tv_time[i]} + {17'd0, lock_r} < {1'b0, now_sec}) begin
        tv_valid[i] = 1'b0;
      end
    end
  endfunction

  function automatic olt_pkg::out_item_t judge(olt_pkg::in_item_t it);
    olt_pkg::out_item_t r;
    int i;
    r.allowed = 1'b1;
    r.table_full = 1'b0;
    if (it.mode == olt_pkg::ModeCheck) begin
      run_sweep();
      i = find_peer(it.peer_address);
      if (i >= 0 && tv_blocked[i]) r.allowed = 1'b0;
    end else if (it.mode == olt_pkg::ModeOffense) begin
      i = find_peer(it.peer_address);
      if (i >= 0 && tv_blocked[i]) begin
        r.allowed = 1'b0;
      end else if (i >= 0) begin
        tv_time[i] = now_sec;
        if (tv_count[i] != olt_pkg::CountMax) tv_count[i]++;
        if (tv_count[i] >= lim_r) begin
          tv_blocked[i] = 1'b1;
          tv_time[i] = add_sat(now_sec, {16'd0, lock_r});
          r.allowed = 1'b0;
        end
      end else begin
        for (i = 0; i < olt_pkg::Entries; i++) if (!tv_valid[i]) break;
        if (i < olt_pkg::Entries) begin
          tv_valid[i] = 1'b1;
          tv_blocked[i] = 1'b0;
          tv_key[i] = it.peer_address;
          tv_count[i] = 8'd1;
          tv_time[i] = now_sec;
        end else begin
          r.table_full = 1'b1;
        end
      end
    end else if (it.mode == olt_pkg::ModeTick) begin
      now_sec = add_sat(now_sec, 32'd1);
    end
    return r;
  endfunction

  // valid stays up after a transfer until the next send inserts an idle gap or drain takes it down
  task automatic send(olt_pkg::in_item_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    verdict_q.push_back(judge(it));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      olt_pkg::RegLimit: lim_r = val[7:0];
      olt_pkg::RegLockout: lock_r = val[15:0];
      olt_pkg::RegInterval: intv_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [7:0] l, logic [15:0] k, logic [15:0] s);
    drain();
    reg_write(olt_pkg::RegLimit, {24'd0, l});
    reg_write(olt_pkg::RegLockout, {16'd0, k});
    reg_write(olt_pkg::RegInterval, {16'd0, s});
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic olt_pkg::in_item_t mk(logic [1:0] m, logic [olt_pkg::KeyW-1:0] a);
    olt_pkg::in_item_t it;
    it.mode = m;
    it.peer_address = a;
    return it;
  endfunction

  task automatic random_run(int n);
    olt_pkg::in_item_t it;
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 30) it = mk(olt_pkg::ModeTick, rand_key());
      else if (r < 60) it = mk(olt_pkg::ModeOffense, keys[$urandom_range(7)]);
      else if (r < 88) it = mk(olt_pkg::ModeCheck, keys[$urandom_range(7)]);
      else if (r < 95) it = mk(olt_pkg::ModeOffense, rand_key());
      else it = mk(2'($urandom_range(3)), rand_key());
      send(it);
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %b", out_item_o);
      end else if (out_item_o !== verdict_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %b act %b", verdict_q[0], out_item_o);
        void'(verdict_q.pop_front());
      end else begin
        void'(verdict_q.pop_front());
      end
    end
    if (holding) out_stall_i <= 1'b1;
    else out_stall_i <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("offense_lockout_table_unit test failed");
      $finish;
    end
  end

  typedef struct {
    olt_pkg::in_item_t  stim;
    bit                 fixed;
    olt_pkg::out_item_t want;
  } row_t;

  initial begin
    row_t rows [9];
    for (int i = 0; i < olt_pkg::Entries; i++) begin
      tv_valid[i] = 0; tv_blocked[i] = 0; tv_key[i] = '0; tv_count[i] = '0; tv_time[i] = '0;
    end
    now_sec = '0; sweep_due_at = '0;
    lim_r = olt_pkg::LimitReset; lock_r = olt_pkg::LockoutReset;
    intv_r = olt_pkg::IntervalReset;
    for (int i = 0; i < 8; i++) keys[i] = rand_key();
    keys[0] = '0; keys[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{mk(olt_pkg::ModeCheck, '0), 1, '{1'b1, 1'b0}},
      '{mk(olt_pkg::ModeOffense, '1), 1, '{1'b1, 1'b0}},
      '{mk(olt_pkg::ModeOffense, '1), 0, '0},
      '{mk(olt_pkg::ModeOffense, '1), 1, '{1'b0, 1'b0}},
      '{mk(olt_pkg::ModeCheck, '1), 1, '{1'b0, 1'b0}},
      '{mk(olt_pkg::ModeOffense, '1), 1, '{1'b0, 1'b0}},
      '{mk(olt_pkg::ModeTick, '0), 1, '{1'b1, 1'b0}},
      '{mk(2'd3, '1), 1, '{1'b1, 1'b0}},
      '{mk(olt_pkg::ModeCheck, 48'h1234_5678_9ABC), 0, '0}
    };
    for (int r = 0; r < $size(rows); r++) begin
      send(rows[r].stim);
      if (rows[r].fixed && verdict_q[$] !== rows[r].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: predictor %b vs table %b", r, verdict_q[$], rows[r].want);
      end
    end
    // fill the table to overflow
    for (int i = 0; i < olt_pkg::Entries + 2; i++)
      send(mk(olt_pkg::ModeOffense, 48'hA000_0000_0000 + i));
    set_regs(8'd2, 16'd1, 16'd1);
    repeat (4) send(mk(olt_pkg::ModeTick, '0));
    send(mk(olt_pkg::ModeCheck, '0));

    random_run(RandItems / 4);
    set_regs(8'd255, 16'd65535, 16'd65535);
    send_idle = 53; recv_idle = 12;
    random_run(RandItems / 4);
    set_regs(8'd4, 16'd3, 16'd2);
    // long receiver hold while items keep coming
    fork
      begin
        holding <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holding <= 1'b0;
      end
      begin
        random_run(20);
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    join
    random_run(RandItems / 4);
    set_regs(8'd3, 16'd10, 16'd5);
    send_idle = 0; recv_idle = 0;
    random_run(RandItems / 4);
    drain();
    if (mismatches == 0) $display("offense_lockout_table_unit test passed");
    else $display("offense_lockout_table_unit test failed");
    $finish;
  end
endmodule
